// File: rtl/sd_spi_init_controller_assert.svh
// Assertion macros shared by the SD SPI start-up controller RTL.
`ifndef SD_SPI_INIT_CONTROLLER_ASSERT_SVH
`define SD_SPI_INIT_CONTROLLER_ASSERT_SVH

`ifndef SYNTH
// Check that a condition implies another in the same cycle.
`define SDI_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("sdi assertion failed");
// Check that a condition implies another in the following cycle.
`define SDI_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sdi assertion failed");
`else
`define SDI_ASSERT_NOW(lbl, pre, post)
`define SDI_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: rtl/sdi_pkg.sv
// Types, constants and helpers for the SD SPI start-up controller.
`timescale 1ns / 1ps
package sdi_pkg;

	// Request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_EXCH  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Outcome codes
	localparam logic [1:0] OUTC_OK      = 2'd0;
	localparam logic [1:0] OUTC_CMD0    = 2'd1;
	localparam logic [1:0] OUTC_TIMEOUT = 2'd2;

	// Result kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_WAKE_BYTES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_TRIES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_BYTES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_TIMEOUT = 3'd5;

	// Register reset values
	localparam logic [7:0]  RST_WAKE_BYTES   = 8'd10;
	localparam logic [7:0]  RST_RESET_TRIES  = 8'd10;
	localparam logic [7:0]  RST_POLL_LIMIT   = 8'd10;
	localparam logic [9:0]  RST_FLUSH_BYTES  = 10'd520;
	localparam logic [15:0] RST_BUSY_TIMEOUT = 16'd300;
	localparam logic [15:0] RST_INIT_TIMEOUT = 16'd2000;

	// Command indexes
	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_IF_COND   = 6'd8;
	localparam logic [5:0] CMD_APP_CMD   = 6'd55;
	localparam logic [5:0] CMD_SEND_OPC  = 6'd41;

	// Bus bytes
	localparam logic [7:0] BYTE_FILL     = 8'hFF;
	localparam logic [7:0] BYTE_STOP     = 8'hFD;
	localparam logic [7:0] BYTE_START    = 8'h40;
	localparam logic [7:0] CRC_CMD0      = 8'h95;
	localparam logic [7:0] CRC_OTHER     = 8'h87;
	localparam logic [7:0] R1_IDLE       = 8'h01;
	localparam logic [7:0] R1_READY      = 8'h00;
	localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
	localparam logic [31:0] ARG_SEND_OPC = 32'h4000_0000;
	localparam logic [2:0] FRAME_LAST    = 3'd5;
	localparam logic [9:0] TRAIL_BYTES   = 10'd4;
	localparam logic [15:0] TIMER_MAX    = 16'hFFFF;

	// Sequencer phases
	typedef enum logic [10:0] {
		PH_IDLE    = 11'b000_0000_0001,
		PH_WAKE    = 11'b000_0000_0010,
		PH_BUSY    = 11'b000_0000_0100,
		PH_FRAME   = 11'b000_0000_1000,
		PH_FILL    = 11'b000_0001_0000,
		PH_POLL    = 11'b000_0010_0000,
		PH_TRAIL   = 11'b000_0100_0000,
		PH_STOP    = 11'b000_1000_0000,
		PH_FLUSH   = 11'b001_0000_0000,
		PH_RELEASE = 11'b010_0000_0000,
		PH_DONE    = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] tx_byte;
		logic       chip_select;
		logic [1:0] outcome;
		logic [7:0] card_response;
	} out_item_t;

	// Byte of a command frame at a given position
	function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic [2:0] pos);
		logic [31:0] arg;
		arg = 32'd0;
		if (cmd == CMD_IF_COND) arg = ARG_IF_COND;
		else if (cmd == CMD_SEND_OPC) arg = ARG_SEND_OPC;
		case (pos)
			3'd0: frame_byte = BYTE_START | {2'b00, cmd};
			3'd1: frame_byte = arg[31:24];
			3'd2: frame_byte = arg[23:16];
			3'd3: frame_byte = arg[15:8];
			3'd4: frame_byte = arg[7:0];
			default: frame_byte = (cmd == CMD_GO_IDLE) ? CRC_CMD0 : CRC_OTHER;
		endcase
	endfunction

endpackage

// File: rtl/sd_spi_init_controller.sv
// Top level of the SD card SPI-mode start-up sequencer.
// A request is held in the input register and its result in the output register.
// Throughput: one request per cycle unless out_stall holds the output; the phase update
//   between the input register and the output register is a single pass of short logic.
// Reset: phase idle, counters and timers zero, response 0xFF, registers at their defaults.
// Ticks never give a result, and exchanges while idle or finished give none.
`timescale 1ns / 1ps
`include "sd_spi_init_controller_assert.svh"
module sd_spi_init_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  sdi_pkg::in_item_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output sdi_pkg::out_item_t                    out_data,
	input  logic                                  cfg_we,
	input  logic [sdi_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sdi_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import sdi_pkg::*;

	// Configuration registers
	logic [7:0]  wake_bytes_q, reset_tries_q, poll_limit_q;
	logic [9:0]  flush_bytes_q;
	logic [15:0] busy_timeout_q, init_timeout_q;

	// Input stage
	logic      in_valid_s1;
	in_item_t  in_s1;

	// Sequencer state
	phase_t      phase_q, phase_d;
	logic [2:0]  fpos_q, fpos_d;
	logic [9:0]  bcnt_q, bcnt_d;
	logic [7:0]  rtry_q, rtry_d;
	logic [15:0] run_q, run_d;
	logic [15:0] busy_q, busy_d;
	logic [5:0]  cmd_q, cmd_d;
	logic [7:0]  resp_q, resp_d;
	logic [1:0]  outc_q, outc_d;

	// Output register
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t res;
	logic      emit;
	logic      advance, fire;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = in_valid_s1 && advance;
	assign in_stall = in_valid_s1 && !advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_bytes_q   <= RST_WAKE_BYTES;
			reset_tries_q  <= RST_RESET_TRIES;
			poll_limit_q   <= RST_POLL_LIMIT;
			flush_bytes_q  <= RST_FLUSH_BYTES;
			busy_timeout_q <= RST_BUSY_TIMEOUT;
			init_timeout_q <= RST_INIT_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WAKE_BYTES:   wake_bytes_q   <= cfg_data[7:0];
				CFG_RESET_TRIES:  reset_tries_q  <= cfg_data[7:0];
				CFG_POLL_LIMIT:   poll_limit_q   <= cfg_data[7:0];
				CFG_FLUSH_BYTES:  flush_bytes_q  <= cfg_data[9:0];
				CFG_BUSY_TIMEOUT: busy_timeout_q <= cfg_data;
				CFG_INIT_TIMEOUT: init_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) in_s1 <= in_data;
	end

	// Work out the next state and the result of one transaction
	always_comb begin
		logic       go_cmd;
		logic [5:0] go_idx;
		logic       go_rel;
		logic [1:0] rel_code;
		logic [9:0] bcnt_inc;
		logic [7:0] rtry_inc;
		logic [7:0] rx;

		phase_d  = phase_q;
		fpos_d   = fpos_q;
		bcnt_d   = bcnt_q;
		rtry_d   = rtry_q;
		run_d    = run_q;
		busy_d   = busy_q;
		cmd_d    = cmd_q;
		resp_d   = resp_q;
		outc_d   = outc_q;
		emit     = 1'b0;
		go_cmd   = 1'b0;
		go_idx   = CMD_GO_IDLE;
		go_rel   = 1'b0;
		rel_code = OUTC_OK;
		bcnt_inc = bcnt_q + 10'd1;
		rtry_inc = rtry_q + 8'd1;
		rx       = in_s1.rx_byte;

		case (in_s1.req_type)
			REQ_START: begin
				emit   = 1'b1;
				run_d  = 16'd0;
				busy_d = 16'd0;
				bcnt_d = 10'd0;
				fpos_d = 3'd0;
				rtry_d = 8'd0;
				cmd_d  = CMD_GO_IDLE;
				resp_d = BYTE_FILL;
				outc_d = OUTC_OK;
				if (wake_bytes_q == 8'd0) go_cmd = 1'b1;
				else phase_d = PH_WAKE;
			end
			REQ_EXCH: begin
				emit = (phase_q != PH_IDLE) && (phase_q != PH_DONE);
				case (phase_q)
					PH_WAKE: begin
						bcnt_d = bcnt_inc;
						if (bcnt_inc >= {2'b00, wake_bytes_q}) go_cmd = 1'b1;
					end
					PH_BUSY: begin
						if (rx == BYTE_FILL || busy_q > busy_timeout_q) begin
							phase_d = PH_FRAME;
							fpos_d  = 3'd0;
						end
					end
					PH_FRAME: begin
						if (fpos_q >= FRAME_LAST) phase_d = PH_FILL;
						else fpos_d = fpos_q + 3'd1;
					end
					PH_FILL: begin
						phase_d = PH_POLL;
						bcnt_d  = 10'd0;
					end
					PH_POLL: begin
						resp_d = rx;
						if (rx[7] && bcnt_q < {2'b00, poll_limit_q}) begin
							bcnt_d = bcnt_inc;
						end else begin
							case (cmd_q)
								CMD_GO_IDLE: begin
									if (rx == R1_IDLE) begin
										go_cmd = 1'b1;
										go_idx = CMD_IF_COND;
									end else begin
										rtry_d = rtry_inc;
										if (rtry_inc == reset_tries_q) begin
											go_rel   = 1'b1;
											rel_code = OUTC_CMD0;
										end else begin
											phase_d = PH_STOP;
										end
									end
								end
								CMD_IF_COND: begin
									phase_d = PH_TRAIL;
									bcnt_d  = 10'd0;
								end
								CMD_APP_CMD: begin
									go_cmd = 1'b1;
									go_idx = CMD_SEND_OPC;
								end
								CMD_SEND_OPC: begin
									if (rx == R1_READY) begin
										go_rel = 1'b1;
									end else if (run_q > init_timeout_q) begin
										go_rel   = 1'b1;
										rel_code = OUTC_TIMEOUT;
									end else begin
										go_cmd = 1'b1;
										go_idx = CMD_APP_CMD;
									end
								end
								default: go_rel = 1'b1;
							endcase
						end
					end
					PH_TRAIL: begin
						bcnt_d = bcnt_inc;
						if (bcnt_inc >= TRAIL_BYTES) begin
							go_cmd = 1'b1;
							go_idx = CMD_APP_CMD;
						end
					end
					PH_STOP: begin
						bcnt_d = 10'd0;
						if (flush_bytes_q == 10'd0) go_cmd = 1'b1;
						else phase_d = PH_FLUSH;
					end
					PH_FLUSH: begin
						bcnt_d = bcnt_inc;
						if (bcnt_inc >= flush_bytes_q) go_cmd = 1'b1;
					end
					PH_RELEASE: phase_d = PH_DONE;
					default: ;
				endcase
			end
			REQ_TICK: begin
				if (run_q != TIMER_MAX) run_d = run_q + 16'd1;
				if (busy_q != TIMER_MAX) busy_d = busy_q + 16'd1;
			end
			default: ;
		endcase

		// Open a command: CMD0 goes straight to its frame, others wait on busy
		if (go_cmd) begin
			cmd_d  = go_idx;
			fpos_d = 3'd0;
			if (go_idx == CMD_GO_IDLE) begin
				phase_d = PH_FRAME;
			end else begin
				phase_d = PH_BUSY;
				busy_d  = 16'd0;
			end
		end
		if (go_rel) begin
			outc_d  = rel_code;
			phase_d = PH_RELEASE;
		end

		// Shape the result for the new phase
		res.result_kind   = KIND_BYTE;
		res.tx_byte       = BYTE_FILL;
		res.chip_select   = 1'b0;
		res.outcome       = outc_d;
		res.card_response = resp_d;
		case (phase_d)
			PH_WAKE:    res.chip_select = 1'b1;
			PH_FRAME:   res.tx_byte = frame_byte(cmd_d, fpos_d);
			PH_STOP:    res.tx_byte = BYTE_STOP;
			PH_RELEASE: res.chip_select = 1'b1;
			PH_DONE: begin
				res.result_kind = KIND_DONE;
				res.tx_byte     = 8'd0;
				res.chip_select = 1'b1;
			end
			default: ;
		endcase
	end

	// Advance the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fpos_q  <= 3'd0;
			bcnt_q  <= 10'd0;
			rtry_q  <= 8'd0;
			run_q   <= 16'd0;
			busy_q  <= 16'd0;
			cmd_q   <= CMD_GO_IDLE;
			resp_q  <= BYTE_FILL;
			outc_q  <= OUTC_OK;
		end else if (fire) begin
			phase_q <= phase_d;
			fpos_q  <= fpos_d;
			bcnt_q  <= bcnt_d;
			rtry_q  <= rtry_d;
			run_q   <= run_d;
			busy_q  <= busy_d;
			cmd_q   <= cmd_d;
			resp_q  <= resp_d;
			outc_q  <= outc_d;
		end
	end

	// Hold or drop the result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks on the sequencer
	`SDI_ASSERT_NOW(a_frame_pos_range, 1'b1, fpos_q <= FRAME_LAST)
	`SDI_ASSERT_NOW(a_busy_not_cmd0, phase_q == PH_BUSY, cmd_q != CMD_GO_IDLE)
	`SDI_ASSERT_NOW(a_done_fields, out_valid_q && out_q.result_kind, (out_q.tx_byte == 8'd0) && out_q.chip_select)
	`SDI_ASSERT_NEXT(a_exch_result, fire && in_s1.req_type == REQ_EXCH && phase_q != PH_IDLE && phase_q != PH_DONE, out_valid_q)
endmodule
